// File: design/bcc_pkg.sv
package bcc_pkg;

  // button lanes that have mask bits; buttons beyond this count stay disabled
  localparam int MASK_W       = 8;
  localparam int BUTTONS_DEF  = 8;
  localparam int CD_W         = 8;
  localparam int IDX_W        = 3;
  localparam int KIND_W       = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - IDX_W - KIND_W;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int QDEPTH       = 2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND,
    PH_HELD,
    PH_COOL,
    PH_DEBOUNCE
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    CK_NONE,
    CK_SINGLE,
    CK_DOUBLE,
    CK_LONG
  } kind_t;

  // one click kind per button of a poll
  typedef kind_t [MASK_W-1:0] kinds_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_WINDOW,
    REG_SECOND_UPPER,
    REG_SECOND_LOWER,
    REG_SINGLE_DEBOUNCE,
    REG_DOUBLE_HOLDOFF,
    REG_LONG_HOLDOFF,
    REG_MULTI_MASK,
    REG_ENABLE_MASK
  } reg_idx_t;

  typedef struct packed {
    logic [CD_W-1:0]   start_window;
    logic [CD_W-1:0]   second_press_upper;
    logic [CD_W-1:0]   second_press_lower;
    logic [CD_W-1:0]   single_debounce;
    logic [CD_W-1:0]   double_holdoff;
    logic [CD_W-1:0]   long_holdoff;
    logic [MASK_W-1:0] multi_click_mask;
    logic [MASK_W-1:0] enable_mask;
  } cfg_t;

  typedef struct packed {
    phase_t          phase;
    logic [CD_W-1:0] cd;
    logic            one_shot;
  } lane_t;

  typedef struct packed {
    lane_t st;
    kind_t kind;
  } lane_res_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// File: design/bcc_front.sv
module bcc_front import bcc_pkg::*; #(
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  q_stat_t               q_stat,
  output logic                  q_push,
  output kinds_t                q_wdata
);

  cfg_t      cfg_r;
  lane_t     lane_r   [BUTTONS];
  lane_res_t lane_res [BUTTONS];
  kinds_t    kinds;
  logic      acc;

  function automatic lane_res_t run_lane(input lane_t s, input logic p, input logic multi,
                                         input logic en, input logic tick, input cfg_t c);
    lane_res_t r;
    r.st   = s;
    r.kind = CK_NONE;
    if (en) begin
      if (r.st.cd == '0 && r.st.phase == PH_IDLE) begin
        if (p) begin
          if (multi) begin
            r.st.cd    = c.start_window;
            r.st.phase = PH_FIRST;
          end else begin
            r.st.cd    = c.single_debounce;
            r.st.phase = PH_DEBOUNCE;
          end
        end else begin
          r.st.one_shot = 1'b0;
        end
      end
      if (r.st.cd < c.second_press_upper && r.st.cd > c.second_press_lower &&
          r.st.phase == PH_FIRST && p)
        r.st.phase = PH_SECOND;
      if (r.st.cd == '0 && r.st.phase == PH_SECOND && p)
        r.st.phase = PH_HELD;
      if (r.st.cd == '0 && r.st.phase == PH_DEBOUNCE) begin
        r.st.phase = PH_COOL;
        if (!r.st.one_shot) begin
          r.st.one_shot = 1'b1;
          r.kind        = CK_SINGLE;
        end
      end
      if (r.st.cd == '0 && r.st.phase == PH_FIRST) begin
        r.st.phase = PH_COOL;
        r.kind     = CK_SINGLE;
      end
      if (r.st.cd == '0 && r.st.phase == PH_SECOND) begin
        r.st.phase = PH_COOL;
        r.st.cd    = c.double_holdoff;
        r.kind     = CK_DOUBLE;
      end
      if (r.st.cd == '0 && r.st.phase == PH_HELD) begin
        r.st.phase = PH_COOL;
        r.st.cd    = c.long_holdoff;
        r.kind     = CK_LONG;
      end
      if (r.st.cd == '0 && r.st.phase == PH_COOL)
        r.st.phase = PH_IDLE;
    end
    if (tick && r.st.cd != '0)
      r.st.cd = r.st.cd - 1'b1;
    return r;
  endfunction

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_window       <= CD_W'(20);
      cfg_r.second_press_upper <= CD_W'(15);
      cfg_r.second_press_lower <= CD_W'(2);
      cfg_r.single_debounce    <= CD_W'(4);
      cfg_r.double_holdoff     <= CD_W'(10);
      cfg_r.long_holdoff       <= CD_W'(20);
      cfg_r.multi_click_mask   <= '1;
      cfg_r.enable_mask        <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_WINDOW:    cfg_r.start_window       <= cfg_data;
        REG_SECOND_UPPER:    cfg_r.second_press_upper <= cfg_data;
        REG_SECOND_LOWER:    cfg_r.second_press_lower <= cfg_data;
        REG_SINGLE_DEBOUNCE: cfg_r.single_debounce    <= cfg_data;
        REG_DOUBLE_HOLDOFF:  cfg_r.double_holdoff     <= cfg_data;
        REG_LONG_HOLDOFF:    cfg_r.long_holdoff       <= cfg_data;
        REG_MULTI_MASK:      cfg_r.multi_click_mask   <= cfg_data;
        REG_ENABLE_MASK:     cfg_r.enable_mask        <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    logic en, p, multi;
    if (b < MASK_W) begin : g_masked
      assign en    = cfg_r.enable_mask[b];
      assign multi = cfg_r.multi_click_mask[b];
      assign p     = in_tdata[b];
    end else begin : g_unmasked
      assign en    = 1'b0;
      assign multi = 1'b0;
      assign p     = 1'b0;
    end

    always_comb lane_res[b] = run_lane(lane_r[b], p, multi, en, in_tuser[0], cfg_r);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lane_r[b].phase    <= PH_IDLE;
        lane_r[b].cd       <= '0;
        lane_r[b].one_shot <= 1'b0;
      end else if (acc) begin
        lane_r[b] <= lane_res[b].st;
      end
    end
  end

  for (genvar k = 0; k < MASK_W; k++) begin : g_kind
    if (k < BUTTONS) begin : g_used
      assign kinds[k] = lane_res[k].kind;
    end else begin : g_unused
      assign kinds[k] = CK_NONE;
    end
  end

  // polls without a click never enter the queue
  assign q_push  = acc && (kinds != '0);
  assign q_wdata = kinds;

endmodule

// File: design/bcc_queue.sv
module bcc_queue import bcc_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  kinds_t  wdata,
  input  logic    pop,
  output q_stat_t stat,
  output kinds_t  rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kinds_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.valid = (count_r != '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)
        count_r <= count_r + 1'b1;
      else if (pop && !push)
        count_r <= count_r - 1'b1;
    end
  end

endmodule

// File: design/bcc_back.sv
module bcc_back import bcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_stat_t                q_stat,
  input  kinds_t                 q_rdata,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  kinds_t             pend_r, pend_nxt, rest;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt, sel;
  kind_t              kind_r, kind_nxt;
  logic               last_r, last_nxt;
  logic               found, take;

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (!found && pend_r[i] != CK_NONE) begin
        found = 1'b1;
        sel   = IDX_W'(i);
      end
    end
    rest      = pend_r;
    rest[sel] = CK_NONE;
  end

  always_comb begin
    take          = !out_valid_r || out_tready;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    if (take && found) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = sel;
      kind_nxt      = pend_r[sel];
      last_nxt      = (rest == '0);
      pend_nxt      = rest;
    end
    q_pop = (pend_nxt == '0) && q_stat.valid;
    if (q_pop)
      pend_nxt = q_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, kind_r, idx_r};
  assign out_tlast  = last_r;

endmodule

// File: design/button_click_classifier_core.sv
// button click classifier: single, double and long press detection per button
//
// in_*   one poll per transfer: in_tdata carries the pressed level of each button,
//        in_tuser carries the 50 ms tick that ages every countdown after the rules
// out_*  one click per transfer, in button order; tlast marks the last click of a poll
// cfg_*  register writes (index, data), always ready; write only while the block is idle
//
// the front holds the per-button phase machines and updates all buttons of a poll
// in parallel in the cycle the poll is taken, so a new poll can be taken every cycle
// while the click queue has room. polls that produce no click leave no trace downstream
// the back drains one queued poll at a time and sends one click per cycle while
// out_tready is high; the first click of a poll passes the queue, the pending register
// and the output register. the result port sets the sustained rate, and a poll carries
// at most 8 clicks
// reset: phases idle, countdowns and one-shot latches cleared, registers at defaults,
// queue and output register empty
// when out_tready is low the output register holds its click, the queue fills and
// in_tready drops once two click-carrying polls are waiting
module button_click_classifier_core import bcc_pkg::*; #(
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pressed_mask[7:0]
  input  logic [0:0]             in_tuser,   // tick[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // button_index[2:0], click_kind[4:3], zero pad
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  kinds_t  q_wdata, q_rdata;

  // front: config registers and per-button phase machines
  bcc_front #(.BUTTONS(BUTTONS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // click vectors of polls waiting for the result channel
  bcc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .stat  (q_stat),
    .rdata (q_rdata)
  );

  // back: serializes clicks in button order into the output register
  bcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a click that is not the last of its poll is followed at once by the next one
  a_next_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("click stream broke inside a poll");

  // clicks of one poll come out in rising button order
  a_button_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[IDX_W-1:0] > $past(out_tdata[IDX_W-1:0]))
    else $error("clicks out of button order");

  // input backpressure only appears after a poll was taken
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("in_tready dropped without an input transfer");

endmodule

// File: dv/bcc_click_checker.sv
module bcc_click_checker import bcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     clicks_pending,
  output int                     mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IDX_W-1:0] button;
    kind_t            kind;
    logic             last;
  } click_t;

  cfg_t            regs;
  phase_t          ph [MASK_W];
  logic [CD_W-1:0] cd [MASK_W];
  logic            shot [MASK_W];
  click_t          clicks_due [$];

  initial begin
    clicks_pending = 0;
    mismatch_count = 0;
  end

  // one button's rules, applied in order; returns the click it reports, if any
  function automatic kind_t advance_button(input int b, input logic p, input logic multi);
    kind_t k;
    k = CK_NONE;
    if (cd[b] == 0 && ph[b] == PH_IDLE) begin
      if (p) begin
        if (multi) begin
          cd[b] = regs.start_window;
          ph[b] = PH_FIRST;
        end else begin
          cd[b] = regs.single_debounce;
          ph[b] = PH_DEBOUNCE;
        end
      end else begin
        shot[b] = 1'b0;
      end
    end
    if (cd[b] < regs.second_press_upper && cd[b] > regs.second_press_lower &&
        ph[b] == PH_FIRST && p)
      ph[b] = PH_SECOND;
    if (cd[b] == 0 && ph[b] == PH_SECOND && p) ph[b] = PH_HELD;
    if (cd[b] == 0 && ph[b] == PH_DEBOUNCE) begin
      ph[b] = PH_COOL;
      if (!shot[b]) begin
        shot[b] = 1'b1;
        k = CK_SINGLE;
      end
    end
    if (cd[b] == 0 && ph[b] == PH_FIRST) begin
      ph[b] = PH_COOL;
      k = CK_SINGLE;
    end
    if (cd[b] == 0 && ph[b] == PH_SECOND) begin
      ph[b] = PH_COOL;
      cd[b] = regs.double_holdoff;
      k = CK_DOUBLE;
    end
    if (cd[b] == 0 && ph[b] == PH_HELD) begin
      ph[b] = PH_COOL;
      cd[b] = regs.long_holdoff;
      k = CK_LONG;
    end
    if (cd[b] == 0 && ph[b] == PH_COOL) ph[b] = PH_IDLE;
    return k;
  endfunction

  function automatic void classify_poll(input logic [MASK_W-1:0] pressed, input logic tick);
    click_t c;
    kind_t  k;
    int     n;
    n = 0;
    for (int b = 0; b < MASK_W; b++) begin
      if (regs.enable_mask[b]) begin
        k = advance_button(b, pressed[b], regs.multi_click_mask[b]);
        if (k != CK_NONE) begin
          c.button = IDX_W'(b);
          c.kind = k;
          c.last = 1'b0;
          clicks_due.push_back(c);
          n++;
        end
      end
    end
    if (n > 0) clicks_due[clicks_due.size()-1].last = 1'b1;
    if (tick) begin
      for (int b = 0; b < MASK_W; b++)
        if (cd[b] != 0) cd[b] = cd[b] - 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    click_t want;
    if (!rst_n) begin
      regs.start_window       = 8'd20;
      regs.second_press_upper = 8'd15;
      regs.second_press_lower = 8'd2;
      regs.single_debounce    = 8'd4;
      regs.double_holdoff     = 8'd10;
      regs.long_holdoff       = 8'd20;
      regs.multi_click_mask   = 8'hFF;
      regs.enable_mask        = 8'hFF;
      for (int b = 0; b < MASK_W; b++) begin
        ph[b] = PH_IDLE;
        cd[b] = '0;
        shot[b] = 1'b0;
      end
      clicks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_WINDOW:    regs.start_window = cfg_data;
          REG_SECOND_UPPER:    regs.second_press_upper = cfg_data;
          REG_SECOND_LOWER:    regs.second_press_lower = cfg_data;
          REG_SINGLE_DEBOUNCE: regs.single_debounce = cfg_data;
          REG_DOUBLE_HOLDOFF:  regs.double_holdoff = cfg_data;
          REG_LONG_HOLDOFF:    regs.long_holdoff = cfg_data;
          REG_MULTI_MASK:      regs.multi_click_mask = cfg_data;
          REG_ENABLE_MASK:     regs.enable_mask = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (clicks_due.size() == 0) begin
          $display("%0t: unexpected click, tdata %h tlast %b", $time, out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = clicks_due.pop_front();
          if (out_tdata[IDX_W-1:0] !== want.button) begin
            $display("%0t: button expected %0d, got %0d", $time, want.button,
                     out_tdata[IDX_W-1:0]);
            mismatch_count++;
          end
          if (out_tdata[IDX_W +: KIND_W] !== want.kind) begin
            $display("%0t: kind expected %0d, got %0d", $time, want.kind,
                     out_tdata[IDX_W +: KIND_W]);
            mismatch_count++;
          end
          if (out_tdata[OUT_TDATA_W-1:IDX_W+KIND_W] !== '0) begin
            $display("%0t: pad expected 0, got %h", $time,
                     out_tdata[OUT_TDATA_W-1:IDX_W+KIND_W]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: tlast expected %b, got %b", $time, want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) classify_poll(in_tdata, in_tuser[0]);
    end
    clicks_pending <= clicks_due.size();
  end

endmodule

// File: dv/tb.sv
module tb;
  import bcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 36;
  localparam int CLICKS_WANTED   = 48;
  localparam int EXTRA_POLLS_MAX = 400;
  localparam int CYCLE_LIMIT     = 800000;
  // registers 8..15 decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(REG_ENABLE_MASK) + 1'b1;

  // register sets used per phase of the run
  typedef enum {CFG_DEFAULT, CFG_SMALL, CFG_ZERO, CFG_WIDE, CFG_FULL} cfg_style_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // pressed_mask[7:0]
  logic [0:0]             in_tuser = '0;   // tick[0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // button_index[2:0], click_kind[4:3], zero pad
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int clicks_pending;
  int mismatch_count;
  int clicks_seen = 0;
  int cycle_count = 0;
  bit calm_in = 1'b0;     // no gaps between polls while set

  // output stall control
  int stall_left = 0;
  int span_left = 0;
  bit calm_out = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  button_click_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bcc_click_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .clicks_pending (clicks_pending),
    .mismatch_count (mismatch_count)
  );

  // count click transfers so the random part knows when results have been plentiful
  always @(posedge clk) begin
    if (out_tvalid && out_tready) clicks_seen++;
  end

  // receiver back-pressure: mostly short stalls, a few long ones, and calm spans with none
  always @(posedge clk) begin
    if (span_left == 0) begin
      span_left <= $urandom_range(64, 400);
      calm_out <= ($urandom_range(0, 3) == 0);
    end else begin
      span_left <= span_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm_out && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one poll transfer; valid stays up when no gap follows
  task automatic poll(input logic [IN_TDATA_W-1:0] mask, input logic tick);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= mask;
    in_tuser <= tick;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every expected click is out, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (clicks_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register load, with one write to an unmapped index mixed in first
  task automatic program_regs(input cfg_t c, input logic [CFG_DATA_W-1:0] junk);
    put_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, 2**CFG_IDX_W - 1)), junk);
    put_reg(REG_START_WINDOW, c.start_window);
    put_reg(REG_SECOND_UPPER, c.second_press_upper);
    put_reg(REG_SECOND_LOWER, c.second_press_lower);
    put_reg(REG_SINGLE_DEBOUNCE, c.single_debounce);
    put_reg(REG_DOUBLE_HOLDOFF, c.double_holdoff);
    put_reg(REG_LONG_HOLDOFF, c.long_holdoff);
    put_reg(REG_MULTI_MASK, c.multi_click_mask);
    put_reg(REG_ENABLE_MASK, c.enable_mask);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(input cfg_style_t style);
    cfg_t c;
    c.multi_click_mask = 8'($urandom);
    c.enable_mask = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
    case (style)
      CFG_DEFAULT: begin
        c = {8'd20, 8'd15, 8'd2, 8'd4, 8'd10, 8'd20, 8'hFF, 8'hFF};
      end
      CFG_SMALL: begin
        c.start_window       = 8'($urandom_range(1, 10));
        c.second_press_upper = 8'($urandom_range(2, 9));
        c.second_press_lower = 8'($urandom_range(0, 3));
        c.single_debounce    = 8'($urandom_range(0, 4));
        c.double_holdoff     = 8'($urandom_range(0, 4));
        c.long_holdoff       = 8'($urandom_range(0, 4));
      end
      CFG_ZERO: begin
        c.start_window       = '0;
        c.second_press_upper = '0;
        c.second_press_lower = '0;
        c.single_debounce    = '0;
        c.double_holdoff     = '0;
        c.long_holdoff       = '0;
      end
      CFG_WIDE: begin
        c.start_window       = 8'($urandom);
        c.second_press_upper = 8'($urandom);
        c.second_press_lower = 8'($urandom);
        c.single_debounce    = 8'($urandom);
        c.double_holdoff     = 8'($urandom);
        c.long_holdoff       = 8'($urandom);
      end
      default: begin
        c.start_window       = 8'hFF;
        c.second_press_upper = 8'hFF;
        c.second_press_lower = 8'hFF;
        c.single_debounce    = 8'hFF;
        c.double_holdoff     = 8'hFF;
        c.long_holdoff       = 8'hFF;
      end
    endcase
    return c;
  endfunction

  // random walk of the pressed levels: buttons mostly held or released for a while
  task automatic wander(inout logic [IN_TDATA_W-1:0] levels, input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) calm_in = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) levels = 8'($urandom);
      else if (r < 12) levels = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else levels ^= 8'($urandom & $urandom & $urandom);
      poll(levels, $urandom_range(0, 99) < 85);
    end
  endtask

  cfg_style_t plan [7] = '{CFG_DEFAULT, CFG_SMALL, CFG_ZERO, CFG_SMALL,
                           CFG_WIDE, CFG_FULL, CFG_SMALL};

  initial begin
    cfg_t c;
    logic [IN_TDATA_W-1:0] levels;
    int extra;
    levels = '0;
    extra = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short windows: button 0 double, 1 long, 2 single; 4-6 single mode held, 7 disabled
    c = {8'd6, 8'd5, 8'd1, 8'd1, 8'd2, 8'd2, 8'h0F, 8'h7F};
    program_regs(c, 8'h00);
    poll(8'hF7, 1'b1);
    poll(8'hF2, 1'b1);
    poll(8'hF3, 1'b1);
    repeat (4) poll(8'hF2, 1'b1);
    poll(8'h02, 1'b0);
    poll(8'h00, 1'b1);
    poll(8'h00, 1'b1);
    poll(8'h00, 1'b0);
    settle();

    // zero timing, all multi: every pressed button clicks at once, eight per poll
    c = make_cfg(CFG_ZERO);
    c.multi_click_mask = 8'hFF;
    c.enable_mask = 8'hFF;
    program_regs(c, 8'hFF);
    poll(8'hFF, 1'b1);
    poll(8'hFF, 1'b0);
    poll(8'h00, 1'b1);
    settle();

    // zero timing, single mode: a held button reports once until released
    c.multi_click_mask = 8'h00;
    program_regs(c, 8'hFF);
    poll(8'hFF, 1'b1);
    poll(8'hFF, 1'b1);
    poll(8'h00, 1'b0);
    poll(8'h55, 1'b1);
    settle();

    // everything disabled, after an unmapped write that must not alias the enable mask
    c.enable_mask = 8'h00;
    program_regs(c, 8'hFF);
    poll(8'hFF, 1'b1);
    poll(8'hAA, 1'b1);
    settle();

    foreach (plan[p]) begin
      program_regs(make_cfg(plan[p]), 8'($urandom));
      wander(levels, ITEMS_PER_PHASE);
      settle();
    end

    // keep going under short windows if clicks were scarce
    if (clicks_seen < CLICKS_WANTED) begin
      program_regs(make_cfg(CFG_SMALL), 8'($urandom));
      while (clicks_seen < CLICKS_WANTED && extra < EXTRA_POLLS_MAX) begin
        wander(levels, 1);
        extra++;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && clicks_pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bcc_pkg.sv
design/bcc_front.sv
design/bcc_queue.sv
design/bcc_back.sv
design/button_click_classifier_core.sv
dv/bcc_click_checker.sv
dv/tb.sv
